// ===== sv/cisd_pkg.sv =====
// Package for the cel image stream decoder: payload structs, result kind
// codes, header constants and queue sizing. No dependencies.
`timescale 1ns / 1ps

package cisd_pkg;

    // One raw byte of the file on the request channel
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_item_t;

    // One decoded result on the result channel
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] col;
        logic [15:0] row;
        logic [7:0]  index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last_pixel;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  depth;
    } out_item_t;

    // Up to two results caused by one byte, as queued between front and back
    typedef struct packed {
        out_item_t res_a;
        out_item_t res_b;
        logic      has_b;
    } entry_t;

    // Result kinds
    localparam logic [1:0] KIND_INDEXED   = 2'd0;
    localparam logic [1:0] KIND_RGBA      = 2'd1;
    localparam logic [1:0] KIND_HEADER    = 2'd2;
    localparam logic [1:0] KIND_BAD_DEPTH = 2'd3;

    // "KiSS" magic, first byte first
    localparam logic [7:0] MAGIC_B0 = 8'h4B;
    localparam logic [7:0] MAGIC_B1 = 8'h69;
    localparam logic [7:0] MAGIC_B2 = 8'h53;
    localparam logic [7:0] MAGIC_B3 = 8'h53;

    localparam logic [5:0] MAGIC_BYTES  = 6'd4;
    localparam logic [5:0] LATCH_END    = 6'd16;
    localparam logic [5:0] HEADER_BYTES = 6'd32;

    localparam logic [7:0] DEPTH_4BPP  = 8'd4;
    localparam logic [7:0] DEPTH_8BPP  = 8'd8;
    localparam logic [7:0] DEPTH_32BPP = 8'd32;

    localparam logic [7:0] TRANSP_4BPP = 8'd16;
    localparam logic [7:0] TRANSP_8BPP = 8'd255;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    localparam int QUEUE_DEPTH = 4;

endpackage

// ===== sv/cisd_front.sv =====
// Front end of the cel image stream decoder: header parser and pixel
// sequencer, one byte per cycle while the queue is not full, writing
// result entries to the queue. Depends on cisd_pkg.
`timescale 1ns / 1ps

module cisd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  cisd_pkg::in_item_t in_data,
    output logic              in_ready,
    output logic              push,
    output cisd_pkg::entry_t  push_data,
    input  logic              q_full
);

    typedef enum logic [1:0] {PH_MAGIC, PH_HEADER, PH_PIXELS, PH_DONE} phase_t;

    phase_t      phase_reg, phase_next;
    logic [5:0]  hc_reg, hc_next;
    logic [7:0]  latch_reg [12];
    logic [7:0]  latch_next [12];
    logic [7:0]  depth_reg, depth_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [1:0]  bip_reg, bip_next;
    logic [7:0]  blue_reg, blue_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  red_reg, red_next;

    logic        accept;
    phase_t      ph;
    logic [5:0]  hc;
    logic [5:0]  hc_off;
    logic [15:0] col;
    logic [15:0] row;
    logic [7:0]  b;
    logic        finish;
    logic [15:0] offx;
    logic [15:0] offy;
    logic [1:0]  step;
    logic [16:0] col1;
    logic [16:0] sum17;
    logic [16:0] row1;
    logic [1:0]  n;
    cisd_pkg::out_item_t res_a;
    cisd_pkg::out_item_t res_b;

    function automatic cisd_pkg::out_item_t mk(
        input logic [1:0]  kind,
        input logic [15:0] c,
        input logic [15:0] r,
        input logic [7:0]  idx,
        input logic [7:0]  rd,
        input logic [7:0]  gr,
        input logic [7:0]  bl,
        input logic [7:0]  al,
        input logic        last
    );
        cisd_pkg::out_item_t it;
        it = '0;
        it.kind       = kind;
        it.col        = c;
        it.row        = r;
        it.index      = idx;
        it.red        = rd;
        it.green      = gr;
        it.blue       = bl;
        it.alpha      = al;
        it.last_pixel = last;
        return it;
    endfunction

    function automatic cisd_pkg::out_item_t indexed(
        input logic [7:0]  code,
        input logic [7:0]  clear_idx,
        input logic [15:0] c,
        input logic [15:0] r,
        input logic        last
    );
        cisd_pkg::out_item_t it;
        if (code == 8'd0) begin
            it = mk(cisd_pkg::KIND_INDEXED, c, r, clear_idx, 8'd0, 8'd0, 8'd0, 8'd0, last);
        end else begin
            it = mk(cisd_pkg::KIND_INDEXED, c, r, code - 8'd1, 8'd0, 8'd0, 8'd0,
                    cisd_pkg::ALPHA_OPAQUE, last);
        end
        return it;
    endfunction

    function automatic logic is_last(
        input logic [15:0] c,
        input logic [15:0] r,
        input logic [15:0] w,
        input logic [15:0] h
    );
        return (({1'b0, c} + 17'd1) == {1'b0, w}) && (({1'b0, r} + 17'd1) == {1'b0, h});
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign b        = in_data.data_byte;

    always_comb begin
        phase_next  = phase_reg;
        hc_next     = hc_reg;
        latch_next  = latch_reg;
        depth_next  = depth_reg;
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        bip_next    = bip_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;
        red_next    = red_reg;
        ph          = phase_reg;
        hc          = hc_reg;
        col         = col_reg;
        row         = row_reg;
        hc_off      = hc_reg - cisd_pkg::MAGIC_BYTES;
        finish      = 1'b0;
        offx        = '0;
        offy        = '0;
        step        = 2'd0;
        col1        = '0;
        sum17       = '0;
        row1        = '0;
        n           = 2'd0;
        res_a       = '0;
        res_b       = '0;

        if (accept) begin
            // a restart byte drops whatever file was in progress
            if (in_data.first_byte) begin
                ph  = PH_MAGIC;
                hc  = '0;
                col = '0;
                row = '0;
                bip_next = 2'd0;
            end
            hc_off     = hc - cisd_pkg::MAGIC_BYTES;
            phase_next = ph;
            hc_next    = hc;
            col_next   = col;
            row_next   = row;

            unique case (ph)
                PH_MAGIC: begin
                    latch_next[{2'b00, hc[1:0]}] = b;
                    hc_next = hc + 6'd1;
                    if (hc_next >= cisd_pkg::MAGIC_BYTES) begin
                        if (latch_next[0] == cisd_pkg::MAGIC_B0 &&
                            latch_next[1] == cisd_pkg::MAGIC_B1 &&
                            latch_next[2] == cisd_pkg::MAGIC_B2 &&
                            latch_next[3] == cisd_pkg::MAGIC_B3) begin
                            phase_next = PH_HEADER;
                        end else begin
                            // old form: the four bytes are width and height
                            depth_next  = cisd_pkg::DEPTH_4BPP;
                            width_next  = {latch_next[1], latch_next[0]};
                            height_next = {latch_next[3], latch_next[2]};
                            finish      = 1'b1;
                        end
                    end
                end
                PH_HEADER: begin
                    if (hc >= cisd_pkg::MAGIC_BYTES && hc < cisd_pkg::LATCH_END) begin
                        latch_next[hc_off[3:0]] = b;
                    end
                    hc_next = hc + 6'd1;
                    if (hc_next >= cisd_pkg::HEADER_BYTES) begin
                        depth_next  = latch_next[1];
                        width_next  = {latch_next[5], latch_next[4]};
                        height_next = {latch_next[7], latch_next[6]};
                        offx        = {latch_next[9], latch_next[8]};
                        offy        = {latch_next[11], latch_next[10]};
                        finish      = 1'b1;
                    end
                end
                PH_PIXELS: begin
                    if (depth_reg == cisd_pkg::DEPTH_4BPP) begin
                        res_a = indexed({4'd0, b[7:4]}, cisd_pkg::TRANSP_4BPP, col, row,
                                        is_last(col, row, width_reg, height_reg));
                        n    = 2'd1;
                        col1 = {1'b0, col} + 17'd1;
                        if (col1 < {1'b0, width_reg}) begin
                            res_b = indexed({4'd0, b[3:0]}, cisd_pkg::TRANSP_4BPP,
                                            col1[15:0], row,
                                            is_last(col1[15:0], row, width_reg, height_reg));
                            n    = 2'd2;
                            step = 2'd2;
                        end else begin
                            // low nibble is row padding
                            step = 2'd1;
                        end
                    end else if (depth_reg == cisd_pkg::DEPTH_8BPP) begin
                        res_a = indexed(b, cisd_pkg::TRANSP_8BPP, col, row,
                                        is_last(col, row, width_reg, height_reg));
                        n    = 2'd1;
                        step = 2'd1;
                    end else begin
                        // 32 bpp: blue, green, red, then alpha completes the pixel
                        case (bip_reg)
                            2'd0: begin
                                blue_next = b;
                                bip_next  = 2'd1;
                            end
                            2'd1: begin
                                green_next = b;
                                bip_next   = 2'd2;
                            end
                            2'd2: begin
                                red_next = b;
                                bip_next = 2'd3;
                            end
                            default: begin
                                res_a = mk(cisd_pkg::KIND_RGBA, col, row, 8'd0, red_reg,
                                           green_reg, blue_reg, b,
                                           is_last(col, row, width_reg, height_reg));
                                n        = 2'd1;
                                bip_next = 2'd0;
                                step     = 2'd1;
                            end
                        endcase
                    end

                    if (step != 2'd0) begin
                        sum17 = {1'b0, col} + {15'd0, step};
                        if (sum17 >= {1'b0, width_reg}) begin
                            col_next = '0;
                            row1     = {1'b0, row} + 17'd1;
                            row_next = row1[15:0];
                            if (row1 >= {1'b0, height_reg}) begin
                                phase_next = PH_DONE;
                            end
                        end else begin
                            col_next = sum17[15:0];
                        end
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase

            if (finish) begin
                res_a = mk(cisd_pkg::KIND_HEADER, offx, offy, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                           1'b0);
                n        = 2'd1;
                col_next = '0;
                row_next = '0;
                bip_next = 2'd0;
                if (height_next == 16'd0) begin
                    phase_next = PH_DONE;
                end else if (depth_next != cisd_pkg::DEPTH_4BPP &&
                             depth_next != cisd_pkg::DEPTH_8BPP &&
                             depth_next != cisd_pkg::DEPTH_32BPP) begin
                    res_b = mk(cisd_pkg::KIND_BAD_DEPTH, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0,
                               8'd0, 8'd0, 1'b0);
                    n          = 2'd2;
                    phase_next = PH_DONE;
                end else if (width_next == 16'd0) begin
                    phase_next = PH_DONE;
                end else begin
                    phase_next = PH_PIXELS;
                end
            end
        end

        // every result carries the header values as they stand after this byte
        res_a.image_width  = width_next;
        res_a.image_height = height_next;
        res_a.depth        = depth_next;
        res_b.image_width  = width_next;
        res_b.image_height = height_next;
        res_b.depth        = depth_next;
    end

    assign push            = accept && (n != 2'd0);
    assign push_data.res_a = res_a;
    assign push_data.res_b = res_b;
    assign push_data.has_b = (n == 2'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_MAGIC;
            hc_reg     <= '0;
            for (int i = 0; i < 12; i++) begin
                latch_reg[i] <= '0;
            end
            depth_reg  <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            bip_reg    <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
            red_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            hc_reg     <= hc_next;
            latch_reg  <= latch_next;
            depth_reg  <= depth_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            bip_reg    <= bip_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            red_reg    <= red_next;
        end
    end

endmodule

// ===== sv/cisd_queue.sv =====
// Small FIFO of result entries between decoder front and back.
// Depends on cisd_pkg.
`timescale 1ns / 1ps

module cisd_queue #(
    parameter int DEPTH = cisd_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  cisd_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output cisd_pkg::entry_t head,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cisd_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/cisd_back.sv =====
// Back end of the cel image stream decoder: splits queued entries into
// single results and drives the registered result channel. Depends on cisd_pkg.
`timescale 1ns / 1ps

module cisd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  cisd_pkg::entry_t    q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output cisd_pkg::out_item_t out_data
);

    logic                out_valid_reg, out_valid_next;
    cisd_pkg::out_item_t out_data_reg, out_data_next;
    logic                spare_valid_reg, spare_valid_next;
    cisd_pkg::out_item_t spare_data_reg, spare_data_next;
    logic                load;

    // output register may take a new result when empty or being drained
    assign load  = !out_valid_reg || out_ready;
    assign q_pop = load && !spare_valid_reg && !q_empty;

    always_comb begin
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        spare_valid_next = spare_valid_reg;
        spare_data_next  = spare_data_reg;
        if (load) begin
            if (spare_valid_reg) begin
                out_valid_next   = 1'b1;
                out_data_next    = spare_data_reg;
                spare_valid_next = 1'b0;
            end else if (!q_empty) begin
                out_valid_next   = 1'b1;
                out_data_next    = q_head.res_a;
                spare_valid_next = q_head.has_b;
                spare_data_next  = q_head.res_b;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
        out_data_reg   <= out_data_next;
        spare_data_reg <= spare_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/cel_image_stream_decoder.sv =====
// Top level of the cel image stream decoder: front parser, entry queue and
// result serializer. Depends on cisd_pkg, cisd_front, cisd_queue, cisd_back.
//
//   channel   ports                          width  carries
//   request   s_valid, s_ready, s_data       9      one file byte, restart flag
//   result    m_valid, m_ready, m_data       115    header, pixel or error result
//
// Flow: a byte is taken every cycle while the entry queue has room. Results
// leave one per cycle from the output register while m_ready is high, so at
// 4 bpp, with two pixels per byte, the result side bounds the byte rate. A
// result is registered in the entry queue, then in the output register.
// Reset: aresetn is synchronous, active low; it clears the parser, queue and
// output valid. Stalls: m_ready low fills the queue, after which s_ready
// drops; the parser never stalls on its own.
`timescale 1ns / 1ps

module cel_image_stream_decoder #(
    parameter int QUEUE_DEPTH = cisd_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cisd_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cisd_pkg::out_item_t m_data
);

    logic             q_push;
    cisd_pkg::entry_t q_push_data;
    logic             q_full;
    logic             q_pop;
    cisd_pkg::entry_t q_head;
    logic             q_empty;

    // Front: header parse and pixel stepping, up to two results per byte
    cisd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .in_ready  (s_ready),
        .push      (q_push),
        .push_data (q_push_data),
        .q_full    (q_full)
    );

    // Queue decouples byte intake from result delivery
    cisd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // Back: one result per cycle into the output register while m_ready is high
    cisd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

`ifndef NO_ASSERTIONS
    // the serializer never pops an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // last_pixel only ever marks pixel results
    a_last_on_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last_pixel) |->
            (m_data.kind == cisd_pkg::KIND_INDEXED || m_data.kind == cisd_pkg::KIND_RGBA))
        else $error("last_pixel on a non-pixel result");

    // rgba results come only from 32 bpp images
    a_rgba_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == cisd_pkg::KIND_RGBA) |->
            (m_data.depth == cisd_pkg::DEPTH_32BPP))
        else $error("rgba result with depth other than 32");

    // indexed results come only from 4 or 8 bpp images
    a_indexed_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == cisd_pkg::KIND_INDEXED) |->
            (m_data.depth == cisd_pkg::DEPTH_4BPP || m_data.depth == cisd_pkg::DEPTH_8BPP))
        else $error("indexed result with depth other than 4 or 8");
`endif

endmodule

// ===== sim/tb_cel_image_stream_decoder.sv =====
// Testbench for the cel image stream decoder: drives file bytes, predicts each
// header, pixel and error result and checks them in order. Depends on cisd_pkg
// and the cel_image_stream_decoder RTL.
`timescale 1ns / 1ps

module tb_cel_image_stream_decoder;

    // Byte positions inside the long (magic) header
    localparam int HDR_DEPTH  = 5;
    localparam int HDR_WIDTH  = 8;
    localparam int HDR_HEIGHT = 10;
    localparam int HDR_OFF_X  = 12;
    localparam int HDR_OFF_Y  = 14;

    localparam int BYTES_PER_PHASE = 257;

    typedef enum logic [1:0] {
        PARSE_MAGIC,
        PARSE_HEADER,
        PARSE_PIXELS,
        PARSE_DONE
    } parse_phase_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    cisd_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    cisd_pkg::out_item_t m_data;

    logic [7:0] magic_word [4] = '{cisd_pkg::MAGIC_B0, cisd_pkg::MAGIC_B1,
                                   cisd_pkg::MAGIC_B2, cisd_pkg::MAGIC_B3};

    // Requests waiting for the driver, results waiting for the monitor
    cisd_pkg::in_item_t  pending_bytes [$];
    cisd_pkg::out_item_t expected_results [$];

    int unsigned send_idle_pct = 38;
    int unsigned recv_idle_pct = 66;
    int unsigned bytes_queued = 0;
    int unsigned requests_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned kind_seen [4] = '{default: 0};
    int unsigned error_count = 0;

    // Decoder shadow state, advanced once per accepted request
    parse_phase_t parse_phase = PARSE_MAGIC;
    logic [5:0]   hdr_count = '0;
    logic [7:0]   hdr_bytes [12] = '{default: 8'h00};
    logic [7:0]   cur_depth = '0;
    logic [15:0]  cur_width = '0;
    logic [15:0]  cur_height = '0;
    int unsigned  cur_col = 0;
    int unsigned  cur_row = 0;
    logic [1:0]   rgba_slot = '0;
    logic [7:0]   held_b = '0;
    logic [7:0]   held_g = '0;
    logic [7:0]   held_r = '0;

    cel_image_stream_decoder u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Result prediction
    // ------------------------------------------------------------------

    // Header values ride along on every result
    function automatic cisd_pkg::out_item_t make_result(logic [1:0] kind, logic [15:0] col,
                                                        logic [15:0] row, logic [7:0] idx,
                                                        logic [7:0] r, logic [7:0] g,
                                                        logic [7:0] b, logic [7:0] a,
                                                        logic last);
        cisd_pkg::out_item_t res;
        res.kind         = kind;
        res.col          = col;
        res.row          = row;
        res.index        = idx;
        res.red          = r;
        res.green        = g;
        res.blue         = b;
        res.alpha        = a;
        res.last_pixel   = last;
        res.image_width  = cur_width;
        res.image_height = cur_height;
        res.depth        = cur_depth;
        return res;
    endfunction

    function automatic logic last_of_image(int unsigned col);
        return (col + 1 == cur_width) && (cur_row + 1 == cur_height);
    endfunction

    // Code zero is transparent; anything else maps to code minus one, opaque
    function automatic cisd_pkg::out_item_t indexed_result(logic [7:0] code,
                                                           logic [7:0] clear_idx,
                                                           int unsigned col);
        if (code == 8'd0)
            return make_result(cisd_pkg::KIND_INDEXED, 16'(col), 16'(cur_row), clear_idx,
                               8'd0, 8'd0, 8'd0, 8'd0, last_of_image(col));
        return make_result(cisd_pkg::KIND_INDEXED, 16'(col), 16'(cur_row), code - 8'd1,
                           8'd0, 8'd0, 8'd0, cisd_pkg::ALPHA_OPAQUE, last_of_image(col));
    endfunction

    function automatic void step_column(int unsigned cols);
        cur_col += cols;
        if (cur_col >= cur_width) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= cur_height)
                parse_phase = PARSE_DONE;
        end
    endfunction

    // Header result, then an error for a bad depth if height is nonzero; empty images stop
    function automatic void close_header(logic [15:0] off_x, logic [15:0] off_y);
        expected_results.push_back(make_result(cisd_pkg::KIND_HEADER, off_x, off_y, 8'd0,
                                               8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        cur_col   = 0;
        cur_row   = 0;
        rgba_slot = '0;
        if (cur_height == 16'd0) begin
            parse_phase = PARSE_DONE;
        end else if (cur_depth != cisd_pkg::DEPTH_4BPP && cur_depth != cisd_pkg::DEPTH_8BPP &&
                     cur_depth != cisd_pkg::DEPTH_32BPP) begin
            expected_results.push_back(make_result(cisd_pkg::KIND_BAD_DEPTH, 16'd0, 16'd0,
                                                   8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
            parse_phase = PARSE_DONE;
        end else if (cur_width == 16'd0) begin
            parse_phase = PARSE_DONE;
        end else begin
            parse_phase = PARSE_PIXELS;
        end
    endfunction

    function automatic void decode_byte(cisd_pkg::in_item_t req);
        logic [7:0] b;
        b = req.data_byte;
        if (req.first_byte) begin
            parse_phase = PARSE_MAGIC;
            hdr_count   = '0;
            cur_col     = 0;
            cur_row     = 0;
            rgba_slot   = '0;
        end
        case (parse_phase)
            PARSE_MAGIC: begin
                hdr_bytes[{2'b00, hdr_count[1:0]}] = b;
                hdr_count++;
                if (hdr_count >= cisd_pkg::MAGIC_BYTES) begin
                    if (hdr_bytes[0] == magic_word[0] && hdr_bytes[1] == magic_word[1] &&
                        hdr_bytes[2] == magic_word[2] && hdr_bytes[3] == magic_word[3]) begin
                        parse_phase = PARSE_HEADER;
                    end else begin
                        // old form: width, height little-endian, always 4 bpp
                        cur_depth  = cisd_pkg::DEPTH_4BPP;
                        cur_width  = {hdr_bytes[1], hdr_bytes[0]};
                        cur_height = {hdr_bytes[3], hdr_bytes[2]};
                        close_header(16'd0, 16'd0);
                    end
                end
            end
            PARSE_HEADER: begin
                if (hdr_count >= cisd_pkg::MAGIC_BYTES && hdr_count < cisd_pkg::LATCH_END)
                    hdr_bytes[4'(hdr_count - cisd_pkg::MAGIC_BYTES)] = b;
                hdr_count++;
                if (hdr_count >= cisd_pkg::HEADER_BYTES) begin
                    cur_depth  = hdr_bytes[HDR_DEPTH - 4];
                    cur_width  = {hdr_bytes[HDR_WIDTH - 3], hdr_bytes[HDR_WIDTH - 4]};
                    cur_height = {hdr_bytes[HDR_HEIGHT - 3], hdr_bytes[HDR_HEIGHT - 4]};
                    close_header({hdr_bytes[HDR_OFF_X - 3], hdr_bytes[HDR_OFF_X - 4]},
                                 {hdr_bytes[HDR_OFF_Y - 3], hdr_bytes[HDR_OFF_Y - 4]});
                end
            end
            PARSE_PIXELS: begin
                if (cur_depth == cisd_pkg::DEPTH_4BPP) begin
                    // high nibble first; low nibble of an odd row end is padding
                    expected_results.push_back(indexed_result({4'h0, b[7:4]},
                                                              cisd_pkg::TRANSP_4BPP,
                                                              cur_col));
                    if (cur_col + 1 < cur_width) begin
                        expected_results.push_back(indexed_result({4'h0, b[3:0]},
                                                                  cisd_pkg::TRANSP_4BPP,
                                                                  cur_col + 1));
                        step_column(2);
                    end else begin
                        step_column(1);
                    end
                end else if (cur_depth == cisd_pkg::DEPTH_8BPP) begin
                    expected_results.push_back(indexed_result(b, cisd_pkg::TRANSP_8BPP,
                                                              cur_col));
                    step_column(1);
                end else begin
                    // file order is blue, green, red, alpha
                    case (rgba_slot)
                        2'd0: begin held_b = b; rgba_slot = 2'd1; end
                        2'd1: begin held_g = b; rgba_slot = 2'd2; end
                        2'd2: begin held_r = b; rgba_slot = 2'd3; end
                        default: begin
                            expected_results.push_back(make_result(cisd_pkg::KIND_RGBA,
                                16'(cur_col), 16'(cur_row), 8'd0, held_r, held_g, held_b,
                                b, last_of_image(cur_col)));
                            rgba_slot = 2'd0;
                            step_column(1);
                        end
                    endcase
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    function automatic string field_diffs(cisd_pkg::out_item_t e, cisd_pkg::out_item_t a);
        string s = "";
        if (a.kind !== e.kind)
            s = {s, $sformatf(" kind exp %0d got %0d", e.kind, a.kind)};
        if (a.col !== e.col)
            s = {s, $sformatf(" col exp %0d got %0d", e.col, a.col)};
        if (a.row !== e.row)
            s = {s, $sformatf(" row exp %0d got %0d", e.row, a.row)};
        if (a.index !== e.index)
            s = {s, $sformatf(" index exp %0d got %0d", e.index, a.index)};
        if (a.red !== e.red)
            s = {s, $sformatf(" red exp %0h got %0h", e.red, a.red)};
        if (a.green !== e.green)
            s = {s, $sformatf(" green exp %0h got %0h", e.green, a.green)};
        if (a.blue !== e.blue)
            s = {s, $sformatf(" blue exp %0h got %0h", e.blue, a.blue)};
        if (a.alpha !== e.alpha)
            s = {s, $sformatf(" alpha exp %0h got %0h", e.alpha, a.alpha)};
        if (a.last_pixel !== e.last_pixel)
            s = {s, $sformatf(" last_pixel exp %0d got %0d", e.last_pixel, a.last_pixel)};
        if (a.image_width !== e.image_width)
            s = {s, $sformatf(" width exp %0d got %0d", e.image_width, a.image_width)};
        if (a.image_height !== e.image_height)
            s = {s, $sformatf(" height exp %0d got %0d", e.image_height, a.image_height)};
        if (a.depth !== e.depth)
            s = {s, $sformatf(" depth exp %0d got %0d", e.depth, a.depth)};
        return s;
    endfunction

    function automatic void check_result(cisd_pkg::out_item_t got);
        cisd_pkg::out_item_t exp;
        string               diffs;
        results_checked++;
        if (expected_results.size() == 0) begin
            note_error($sformatf("result with nothing expected: kind %0d col %0d row %0d",
                                 got.kind, got.col, got.row));
        end else begin
            exp = expected_results.pop_front();
            kind_seen[exp.kind]++;
            diffs = field_diffs(exp, got);
            if (diffs != "")
                note_error($sformatf("result %0d:%s", results_checked, diffs));
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    function automatic void queue_byte(logic [7:0] b, logic first);
        cisd_pkg::in_item_t req;
        req.data_byte  = b;
        req.first_byte = first;
        pending_bytes.push_back(req);
        bytes_queued++;
    endfunction

    // Bytes of pixel data a complete image needs, rows padded to whole bytes
    function automatic longint unsigned image_bytes(logic [7:0] depth, logic [15:0] w,
                                                    logic [15:0] h);
        longint unsigned per_row;
        case (depth)
            cisd_pkg::DEPTH_4BPP:  per_row = (longint'(w) + 1) / 2;
            cisd_pkg::DEPTH_8BPP:  per_row = longint'(w);
            cisd_pkg::DEPTH_32BPP: per_row = 4 * longint'(w);
            default:               per_row = 0;
        endcase
        return per_row * longint'(h);
    endfunction

    // One file: header, then random body bytes; keep cuts it short or runs past the end.
    // The first byte always carries the restart flag.
    function automatic void send_file(logic kiss, logic [7:0] depth, logic [15:0] w,
                                      logic [15:0] h, logic [15:0] off_x,
                                      logic [15:0] off_y, longint unsigned keep);
        logic [7:0]  b;
        logic [31:0] old_hdr;
        old_hdr = {h, w};
        for (longint unsigned i = 0; i < keep; i++) begin
            if (kiss && i < cisd_pkg::HEADER_BYTES) begin
                case (i)
                    0, 1, 2, 3:     b = magic_word[i];
                    HDR_DEPTH:      b = depth;
                    HDR_WIDTH:      b = w[7:0];
                    HDR_WIDTH + 1:  b = w[15:8];
                    HDR_HEIGHT:     b = h[7:0];
                    HDR_HEIGHT + 1: b = h[15:8];
                    HDR_OFF_X:      b = off_x[7:0];
                    HDR_OFF_X + 1:  b = off_x[15:8];
                    HDR_OFF_Y:      b = off_y[7:0];
                    HDR_OFF_Y + 1:  b = off_y[15:8];
                    default:        b = 8'($urandom);
                endcase
            end else if (!kiss && i < cisd_pkg::MAGIC_BYTES) begin
                b = old_hdr[8 * i +: 8];
            end else begin
                // lean on the transparent and all-ones codes
                case ($urandom_range(0, 7))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom);
                endcase
            end
            queue_byte(b, i == 0);
        end
    endfunction

    // Mostly well-formed small files with random content; some cut short, some with
    // trailing bytes, some with unknown depths or huge sizes, plus loose noise bytes
    function automatic void random_file();
        int unsigned     pick;
        logic            kiss;
        logic [7:0]      depth;
        logic [15:0]     w;
        logic [15:0]     h;
        longint unsigned hdr_len;
        longint unsigned whole;
        longint unsigned keep;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            repeat ($urandom_range(1, 6))
                queue_byte(8'($urandom), $urandom_range(0, 7) == 0);
            return;
        end
        kiss = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 19);
        if (!kiss || pick < 7)
            depth = cisd_pkg::DEPTH_4BPP;
        else if (pick < 13)
            depth = cisd_pkg::DEPTH_8BPP;
        else if (pick < 18)
            depth = cisd_pkg::DEPTH_32BPP;
        else
            depth = 8'($urandom);
        w = ($urandom_range(0, 15) == 0) ? 16'd0
            : 16'($urandom_range(1, depth == cisd_pkg::DEPTH_32BPP ? 4 : 9));
        h = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
        if ($urandom_range(0, 39) == 0) begin
            if ($urandom_range(0, 1))
                w = 16'($urandom);
            else
                h = 16'($urandom);
        end
        hdr_len = kiss ? cisd_pkg::HEADER_BYTES : cisd_pkg::MAGIC_BYTES;
        whole   = hdr_len + image_bytes(depth, w, h);
        pick    = $urandom_range(0, 9);
        if (pick < 6)
            keep = whole;
        else if (pick < 8)
            keep = whole + $urandom_range(1, 6);
        else
            keep = 1 + longint'($urandom) % (whole - 1);
        // huge images only get a glimpse of their body
        if (keep > hdr_len + 80)
            keep = hdr_len + $urandom_range(0, 40);
        send_file(kiss, depth, w, h, 16'($urandom), 16'($urandom), keep);
    endfunction

    task automatic drain_requests();
        while (pending_bytes.size() != 0 || s_valid)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Request driver: predicts on every accepted byte, then offers the next one
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_data);
                requests_accepted++;
            end
            // valid holds until accepted; a new byte only once the slot is free
            if (!s_valid || s_ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_data  <= pending_bytes.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor with random backpressure
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                check_result(m_data);
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned send_pcts [3] = '{38, 66, 0};
        int unsigned recv_pcts [3] = '{66, 38, 0};
        int unsigned base;
        int unsigned guard;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Old form 3x2 at 4 bpp: transparent nibbles, code 15 and odd-width padding
        send_file(1'b0, cisd_pkg::DEPTH_4BPP, 16'd3, 16'd2, 16'd0, 16'd0,
                  cisd_pkg::MAGIC_BYTES);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h1F, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'hA5, 1'b0);
        // 8 bpp 2x2 with max offsets, transparent and extreme codes, trailing bytes
        send_file(1'b1, cisd_pkg::DEPTH_8BPP, 16'd2, 16'd2, 16'hFFFF, 16'hFFFF,
                  cisd_pkg::HEADER_BYTES);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h12, 1'b0);
        queue_byte(8'h34, 1'b0);
        // 32 bpp 2x1: channel reorder, alpha zero and full
        send_file(1'b1, cisd_pkg::DEPTH_32BPP, 16'd2, 16'd1, 16'd0, 16'd0,
                  cisd_pkg::HEADER_BYTES);
        queue_byte(8'h10, 1'b0);
        queue_byte(8'h20, 1'b0);
        queue_byte(8'h30, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFE, 1'b0);
        queue_byte(8'hFD, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // unsupported depth: error result, body ignored
        send_file(1'b1, 8'd24, 16'd5, 16'd1, 16'h1234, 16'h5678, cisd_pkg::HEADER_BYTES + 3);
        // empty images: zero width, then zero height with an unknown depth
        send_file(1'b1, cisd_pkg::DEPTH_8BPP, 16'd0, 16'd3, 16'd7, 16'd9,
                  cisd_pkg::HEADER_BYTES + 2);
        send_file(1'b1, 8'd77, 16'd4, 16'd0, 16'd0, 16'd0, cisd_pkg::HEADER_BYTES);
        // largest old-form image, cut short by the next restart
        send_file(1'b0, cisd_pkg::DEPTH_4BPP, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0,
                  cisd_pkg::MAGIC_BYTES + 3);
        // restart inside a long header, then a 1x1 old-form image with padding
        send_file(1'b1, cisd_pkg::DEPTH_4BPP, 16'd1, 16'd2, 16'd0, 16'd0, 20);
        send_file(1'b0, cisd_pkg::DEPTH_4BPP, 16'd1, 16'd1, 16'd0, 16'd0,
                  cisd_pkg::MAGIC_BYTES);
        queue_byte(8'h10, 1'b0);
        // near miss on the magic word falls back to the old form
        send_file(1'b0, cisd_pkg::DEPTH_4BPP, 16'h694B, 16'h0053, 16'd0, 16'd0,
                  cisd_pkg::MAGIC_BYTES + 2);
        // widest 4 bpp row, truncated
        send_file(1'b1, cisd_pkg::DEPTH_4BPP, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0,
                  cisd_pkg::HEADER_BYTES + 2);
        // 32 bpp pixel cut mid-way by a restart
        send_file(1'b1, cisd_pkg::DEPTH_32BPP, 16'd1, 16'd1, 16'd0, 16'hFFFF,
                  cisd_pkg::HEADER_BYTES + 3);
        send_file(1'b1, cisd_pkg::DEPTH_32BPP, 16'd1, 16'd1, 16'd3, 16'd4,
                  cisd_pkg::HEADER_BYTES + 4);

        // Random files in three backpressure phases
        base = bytes_queued;
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = send_pcts[p];
            recv_idle_pct = recv_pcts[p];
            while (bytes_queued < base + (p + 1) * BYTES_PER_PHASE)
                random_file();
            drain_requests();
        end

        // Wait out the results still in flight, then keep watching for strays
        guard = 0;
        while (expected_results.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        if (expected_results.size() != 0)
            note_error($sformatf("%0d expected results never arrived",
                                 expected_results.size()));

        $display("Summary: %0d request bytes accepted, %0d results checked", requests_accepted,
                 results_checked);
        $display("Summary: indexed %0d, rgba %0d, header %0d, bad depth %0d; %0d errors",
                 kind_seen[cisd_pkg::KIND_INDEXED], kind_seen[cisd_pkg::KIND_RGBA],
                 kind_seen[cisd_pkg::KIND_HEADER], kind_seen[cisd_pkg::KIND_BAD_DEPTH],
                 error_count);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial begin
        #3_000_000;
        $display("ERROR: watchdog expired with %0d results outstanding",
                 expected_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== cel_image_stream_decoder.f =====
sv/cisd_pkg.sv
sv/cisd_front.sv
sv/cisd_queue.sv
sv/cisd_back.sv
sv/cel_image_stream_decoder.sv
sim/tb_cel_image_stream_decoder.sv
